// ===== hdl/lzss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_pkg
// Shared types, constants and token selection for the lzss byte-group
// decompressor.
// ----------------------------------------------------------------------------
package lzss_pkg;

  localparam int unsigned FLAG_BITS   = 8;   // tokens per flag byte
  localparam int unsigned POS_W       = 4;   // bit position, holds 0..8
  localparam int unsigned DIST_W      = 14;  // 12-bit distance code times group size
  localparam int unsigned LEN_W       = 7;   // unclipped length, up to 54
  localparam int unsigned RUN_W       = 6;   // clipped length, up to 51
  localparam int unsigned MAX_RUN     = 51;  // longest reference
  localparam int unsigned ADDR_W      = 4;   // apb byte address
  localparam int unsigned DATA_W      = 32;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_GROUP = 2'd0;
  localparam logic [1:0] REG_BIAS  = 2'd1;
  localparam logic [1:0] REG_LIMIT = 2'd2;

  // parser phase
  typedef enum logic [3:0] {
    PH_FLAG   = 4'b0001,
    PH_LIT    = 4'b0010,
    PH_REF_LO = 4'b0100,
    PH_REF_HI = 4'b1000
  } phase_e;

  // sequencer state
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_HOLD = 4'b0010,
    S_RD   = 4'b0100,
    S_WR   = 4'b1000
  } state_e;

  typedef struct packed {
    phase_e           phase;
    logic [POS_W-1:0] pos;
    logic [1:0]       lit_left;
  } token_t;

  // picks the token at or after pos; with a zero group size literal bits
  // are skipped until a reference bit turns up
  function automatic token_t choose_token(logic [FLAG_BITS-1:0] flags,
                                          logic [POS_W-1:0] pos,
                                          logic [1:0] group);
    token_t t;
    logic   found;
    int     i;
    t.phase    = PH_FLAG;
    t.pos      = pos;
    t.lit_left = 2'd0;
    found      = 1'b0;
    if (pos < POS_W'(FLAG_BITS)) begin
      if (group != 2'd0) begin
        if (flags[pos[2:0]]) begin
          t.phase    = PH_LIT;
          t.lit_left = group;
        end else begin
          t.phase = PH_REF_LO;
        end
      end else begin
        for (i = 0; i < FLAG_BITS; i++) begin
          if (!found && (i >= int'(pos)) && !flags[i]) begin
            found   = 1'b1;
            t.pos   = POS_W'(i);
            t.phase = PH_REF_LO;
          end
        end
        if (!found) begin
          t.pos = POS_W'(FLAG_BITS);
        end
      end
    end
    return t;
  endfunction

endpackage

// ===== hdl/lzss_byte_group_decompressor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_byte_group_decompressor
// Expands an lzss stream of flag bytes, literal groups and two-byte window
// references into decompressed bytes, with a history window held in one
// synchronous ram.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  ------------------------------------
//  in        sink       in_valid_i/in_ready_o  in_byte_i, in_end_i
//  out       source     out_valid_o/out_ready_i out_byte_o, run_last_o,
//                                              output_done_o, bad_reference_o
//  cfg       apb slave  psel/penable/pready    group_bytes, length_bias, output_limit
//
//  flag, reference-low and skipped bytes are taken in the idle state; a literal
//  byte waits in the hold state when the output register is still full
//  in a reference each copied byte needs a window read state and a write-back
//  state, through the single ram port pair
//  the window ram has no reset and no clearing pass; stream reads only reach
//  entries already written in that stream
//  a stalled output holds the sequencer in its write-back or hold state
//
module lzss_byte_group_decompressor #(
  parameter int unsigned WINDOW_DEPTH = 16384
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // compressed stream
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     in_byte_i,
  input  logic                           in_end_i,
  // decompressed bytes
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     out_byte_o,
  output logic                           run_last_o,
  output logic                           output_done_o,
  output logic                           bad_reference_o,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lzss_pkg::ADDR_W-1:0]    paddr,
  input  logic [lzss_pkg::DATA_W-1:0]    pwdata,
  output logic [lzss_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);
  import lzss_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);

  // configuration registers
  logic [1:0]        group_q, group_d;
  logic [1:0]        bias_q, bias_d;
  logic [31:0]       limit_q, limit_d;

  // parser state
  logic [7:0]        flags_q, flags_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  phase_e            phase_q, phase_d;
  logic [1:0]        lit_left_q, lit_left_d;
  logic [7:0]        ref_lo_q, ref_lo_d;

  // stream counters
  logic [31:0]       count_q, count_d;
  logic [AW-1:0]     wp_q, wp_d;

  // sequencer
  state_e            state_q, state_d;
  logic              end_q, end_d;
  logic [DIST_W-1:0] dist_q, dist_d;
  logic [RUN_W-1:0]  remain_q, remain_d;
  logic              bad_q, bad_d;

  // held literal while the output register is full
  logic [7:0]        hold_byte_q, hold_byte_d;
  logic              hold_done_q, hold_done_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_byte_q, out_byte_d;
  logic              out_last_q, out_last_d;
  logic              out_done_q, out_done_d;
  logic              out_bad_q, out_bad_d;

  // window ram
  logic [7:0]        mem [WINDOW_DEPTH];
  logic              mem_we, mem_re;
  logic [7:0]        mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [7:0]        rd_data_q;

  // helpers
  logic              slot_free;
  logic              cfg_write;
  logic [AW-1:0]     wp_next;
  logic [31:0]       count_inc;
  logic              hits_limit;
  logic [15:0]       code;
  logic [4:0]        len_units;
  logic [LEN_W-1:0]  len_raw;
  logic [RUN_W-1:0]  len_clip;
  logic [31:0]       wp_ext, dist_ext, base;
  logic [7:0]        copy_byte;
  logic              copy_last;
  logic              copy_start;
  token_t            tok;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign cfg_write  = psel && penable && pwrite;
  assign wp_next    = (wp_q == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_q + 1'b1;
  assign count_inc  = count_q + 32'd1;
  assign hits_limit = (count_inc == limit_q);

  // reference decode
  assign code      = {in_byte_i, ref_lo_q};
  assign len_units = {1'b0, code[3:0]} + {3'b0, bias_q};
  assign len_raw   = LEN_W'(len_units) * LEN_W'(group_q);
  assign len_clip  = (len_raw > LEN_W'(MAX_RUN)) ? RUN_W'(MAX_RUN) : len_raw[RUN_W-1:0];

  // window address of the byte dist back, wrapping at the window depth
  assign wp_ext    = 32'(wp_q);
  assign dist_ext  = 32'(dist_q);
  assign base      = (wp_ext >= dist_ext) ? wp_ext : wp_ext + 32'(WINDOW_DEPTH);
  assign mem_raddr = AW'(base - dist_ext);

  assign copy_byte = bad_q ? 8'd0 : rd_data_q;
  assign copy_last = (remain_q == RUN_W'(1)) || hits_limit;

  always_comb begin
    group_d     = group_q;
    bias_d      = bias_q;
    limit_d     = limit_q;
    flags_d     = flags_q;
    pos_d       = pos_q;
    phase_d     = phase_q;
    lit_left_d  = lit_left_q;
    ref_lo_d    = ref_lo_q;
    count_d     = count_q;
    wp_d        = wp_q;
    state_d     = state_q;
    end_d       = end_q;
    dist_d      = dist_q;
    remain_d    = remain_q;
    bad_d       = bad_q;
    hold_byte_d = hold_byte_q;
    hold_done_d = hold_done_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_done_d  = out_done_q;
    out_bad_d   = out_bad_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_wdata   = in_byte_i;
    copy_start  = 1'b0;
    tok         = choose_token(flags_q, 4'(pos_q + 4'd1), group_q);

    // the user must write registers only while the block is idle; the block does not enforce it
    if (cfg_write) begin
      unique case (paddr[3:2])
        REG_GROUP: group_d = pwdata[1:0];
        REG_BIAS:  bias_d  = pwdata[1:0];
        REG_LIMIT: limit_d = pwdata;
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (count_q < limit_q) begin
            unique case (phase_q)
              PH_FLAG: begin
                flags_d    = in_byte_i;
                tok        = choose_token(in_byte_i, '0, group_q);
                phase_d    = tok.phase;
                pos_d      = tok.pos;
                lit_left_d = tok.lit_left;
              end
              PH_LIT: begin
                // literal goes to the window and the counters right away
                mem_we    = 1'b1;
                mem_wdata = in_byte_i;
                wp_d      = wp_next;
                count_d   = count_inc;
                if (slot_free) begin
                  out_valid_d = 1'b1;
                  out_byte_d  = in_byte_i;
                  out_last_d  = 1'b1;
                  out_done_d  = hits_limit;
                  out_bad_d   = 1'b0;
                end else begin
                  hold_byte_d = in_byte_i;
                  hold_done_d = hits_limit;
                  state_d     = S_HOLD;
                end
                if (lit_left_q <= 2'd1) begin
                  lit_left_d = 2'd0;
                  phase_d    = tok.phase;
                  pos_d      = tok.pos;
                  lit_left_d = tok.lit_left;
                end else begin
                  lit_left_d = lit_left_q - 2'd1;
                end
              end
              PH_REF_LO: begin
                ref_lo_d = in_byte_i;
                phase_d  = PH_REF_HI;
              end
              PH_REF_HI: begin
                dist_d     = DIST_W'(code[15:4]) * DIST_W'(group_q);
                remain_d   = len_clip;
                phase_d    = tok.phase;
                pos_d      = tok.pos;
                lit_left_d = tok.lit_left;
                if (len_clip != '0) begin
                  copy_start = 1'b1;
                  end_d      = in_end_i;
                  state_d    = S_RD;
                end
              end
              default: phase_d = PH_FLAG;
            endcase
          end
          if (in_end_i) begin
            // parser restarts now, counters once a pending copy is done
            flags_d    = '0;
            pos_d      = '0;
            phase_d    = PH_FLAG;
            lit_left_d = 2'd0;
            ref_lo_d   = '0;
            if (!copy_start) begin
              count_d = '0;
              wp_d    = '0;
            end
          end
        end
      end
      S_HOLD: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = hold_byte_q;
          out_last_d  = 1'b1;
          out_done_d  = hold_done_q;
          out_bad_d   = 1'b0;
          state_d     = S_IDLE;
        end
      end
      S_RD: begin
        // bad test per byte, so later bytes of a reference may become good
        mem_re  = 1'b1;
        bad_d   = (dist_q == '0) || (dist_ext > count_q) ||
                  (dist_ext > 32'(WINDOW_DEPTH));
        state_d = S_WR;
      end
      S_WR: begin
        if (slot_free) begin
          mem_we      = 1'b1;
          mem_wdata   = copy_byte;
          wp_d        = wp_next;
          count_d     = count_inc;
          out_valid_d = 1'b1;
          out_byte_d  = copy_byte;
          out_last_d  = copy_last;
          out_done_d  = hits_limit;
          out_bad_d   = bad_q;
          remain_d    = remain_q - RUN_W'(1);
          if (copy_last) begin
            state_d = S_IDLE;
            if (end_q) begin
              count_d = '0;
              wp_d    = '0;
              end_d   = 1'b0;
            end
          end else begin
            state_d = S_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q     <= 2'd1;
      bias_q      <= 2'd2;
      limit_q     <= '0;
      flags_q     <= '0;
      pos_q       <= '0;
      phase_q     <= PH_FLAG;
      lit_left_q  <= 2'd0;
      ref_lo_q    <= '0;
      count_q     <= '0;
      wp_q        <= '0;
      state_q     <= S_IDLE;
      end_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      group_q     <= group_d;
      bias_q      <= bias_d;
      limit_q     <= limit_d;
      flags_q     <= flags_d;
      pos_q       <= pos_d;
      phase_q     <= phase_d;
      lit_left_q  <= lit_left_d;
      ref_lo_q    <= ref_lo_d;
      count_q     <= count_d;
      wp_q        <= wp_d;
      state_q     <= state_d;
      end_q       <= end_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    dist_q      <= dist_d;
    remain_q    <= remain_d;
    bad_q       <= bad_d;
    hold_byte_q <= hold_byte_d;
    hold_done_q <= hold_done_d;
    out_byte_q  <= out_byte_d;
    out_last_q  <= out_last_d;
    out_done_q  <= out_done_d;
    out_bad_q   <= out_bad_d;
  end

  // history window, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wp_q] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_raddr];
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[3:2])
      REG_GROUP: prdata = {30'd0, group_q};
      REG_BIAS:  prdata = {30'd0, bias_q};
      REG_LIMIT: prdata = limit_q;
      default:   prdata = '0;
    endcase
  end

  assign pready          = 1'b1;
  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign run_last_o      = out_last_q;
  assign output_done_o   = out_done_q;
  assign bad_reference_o = out_bad_q;

endmodule
